@@ hw/rtl/periodic_beacon_flow_detector_unit_assert.svh @@
// Assertion macros for the periodic beacon flow detector.
// Expects clk and rst to be visible where the macros are used.
`ifndef PERIODIC_BEACON_FLOW_DETECTOR_UNIT_ASSERT_SVH
`define PERIODIC_BEACON_FLOW_DETECTOR_UNIT_ASSERT_SVH
`define PBFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define PBFD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ hw/rtl/pbfd_pkg.sv @@
// Package for the periodic beacon flow detector: sizes, codes and beat types.
// Has no dependencies; used by periodic_beacon_flow_detector_unit.
package pbfd_pkg;

  localparam int TRACK_ENTRIES     = 64;
  localparam int SAMPLES_PER_TRACK = 16;

  localparam int ENTRY_W   = (TRACK_ENTRIES > 1) ? $clog2(TRACK_ENTRIES) : 1;
  localparam int COUNT_W   = $clog2(TRACK_ENTRIES + 1);
  localparam int SLOT_W    = $clog2(SAMPLES_PER_TRACK);
  localparam int HELD_W    = $clog2(SAMPLES_PER_TRACK + 1);
  localparam int ARR_DEPTH = TRACK_ENTRIES * SAMPLES_PER_TRACK;
  localparam int ARR_AW    = $clog2(ARR_DEPTH);
  localparam int GAP_W     = $clog2(SAMPLES_PER_TRACK);
  localparam int SUM_W     = 33 + GAP_W;
  localparam int S_W       = SUM_W - 1;
  localparam int SQ_W      = 64 + GAP_W;
  localparam int S2_W      = 2 * S_W;
  localparam int LHS_W     = S2_W + 16;
  localparam int DIVN_W    = S_W + 8;
  localparam int DIVC_W    = $clog2(DIVN_W + 1);
  localparam int MULC_W    = $clog2(S_W + 1);
  localparam int CW        = GAP_W + 9;

  typedef enum logic [1:0] {
    FUNC_SIGHT    = 2'd0,
    FUNC_OBSERVE  = 2'd1,
    FUNC_CLASSIFY = 2'd2,
    FUNC_NONE     = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    CFG_REFRESH_GAP     = 3'd0,
    CFG_MIN_SAMPLES_LJ  = 3'd1,
    CFG_MIN_SAMPLES_CON = 3'd2,
    CFG_MIN_INTERVAL    = 3'd3,
    CFG_MAX_JITTER      = 3'd4,
    CFG_MIN_CONC        = 3'd5
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_CL_RD, S_CL_DAT, S_CL_MUL, S_CL_ACC, S_POST,
    S_MEAN_DIV, S_SQ_MUL, S_RHS_MUL, S_T1_CMP, S_CONC, S_MED, S_MED_CHK,
    S_WIN, S_CONC_INIT, S_CONC_DIV, S_CONC_END, S_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [15:0] remote_port_num;
    logic [31:0] time_now;
  } pbfd_item_t;

  typedef struct packed {
    logic        hit;
    logic [1:0]  strength;
    logic [4:0]  arrival_count;
    logic [31:0] median_gap;
    logic [39:0] mean_gap_q8;
    logic [8:0]  concentration_q8;
  } pbfd_result_t;

  typedef struct packed {
    logic [63:0]       addr_hi;
    logic [63:0]       addr_lo;
    logic [15:0]       port;
    logic [31:0]       last_seen;
    logic [SLOT_W-1:0] write_slot;
    logic [HELD_W-1:0] held;
  } pbfd_meta_t;

endpackage

@@ hw/rtl/periodic_beacon_flow_detector_unit.sv @@
// Sighting and observe beats do a one-entry-per-cycle scan of the flow table memory,
// then a single read-modify-write.
// Classify beats also run the median search, which rotates the 16-slot gap ring in full
// for every candidate, and the serial divider and multiplier.
// One beat at a time; done pulses for one cycle and busy is already low then.
// Synchronous reset empties the table and restores the register defaults.
`include "periodic_beacon_flow_detector_unit_assert.svh"

module periodic_beacon_flow_detector_unit (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  pbfd_pkg::pbfd_item_t   item,
  output logic                   done,
  output pbfd_pkg::pbfd_result_t result,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [15:0]            cfg_data
);

  localparam int TE     = pbfd_pkg::TRACK_ENTRIES;
  localparam int SP     = pbfd_pkg::SAMPLES_PER_TRACK;
  localparam int ENTRY_W = pbfd_pkg::ENTRY_W;
  localparam int COUNT_W = pbfd_pkg::COUNT_W;
  localparam int SLOT_W = pbfd_pkg::SLOT_W;
  localparam int HELD_W = pbfd_pkg::HELD_W;
  localparam int ARR_AW = pbfd_pkg::ARR_AW;
  localparam int GAP_W  = pbfd_pkg::GAP_W;
  localparam int SUM_W  = pbfd_pkg::SUM_W;
  localparam int S_W    = pbfd_pkg::S_W;
  localparam int SQ_W   = pbfd_pkg::SQ_W;
  localparam int S2_W   = pbfd_pkg::S2_W;
  localparam int LHS_W  = pbfd_pkg::LHS_W;
  localparam int DIVN_W = pbfd_pkg::DIVN_W;
  localparam int DIVC_W = pbfd_pkg::DIVC_W;
  localparam int MULC_W = pbfd_pkg::MULC_W;
  localparam int CW     = pbfd_pkg::CW;

  pbfd_pkg::state_t state, state_next;

  logic [15:0] cfg_refresh_gap, cfg_min_interval;
  logic [4:0]  cfg_min_lj, cfg_min_con;
  logic [7:0]  cfg_max_jitter;
  logic [8:0]  cfg_min_conc;

  pbfd_pkg::pbfd_item_t req;
  logic [COUNT_W-1:0] cnt, scan_cnt;
  logic               pend_vld;
  logic [ENTRY_W-1:0] pend_idx, hit_idx, vic_idx;
  logic               hit_r;
  pbfd_pkg::pbfd_meta_t hit_meta;
  logic [31:0]        vic_ls;

  pbfd_pkg::pbfd_meta_t meta_mem [TE];
  pbfd_pkg::pbfd_meta_t meta_rd, meta_wdata, rec_meta, base_meta;
  logic               meta_we;
  logic [ENTRY_W-1:0] meta_waddr, meta_raddr, new_idx;

  logic [31:0]       arr_mem [pbfd_pkg::ARR_DEPTH];
  logic [31:0]       arr_rd;
  logic              arr_we;
  logic [ARR_AW-1:0] arr_waddr, arr_raddr;

  logic [HELD_W-1:0] ld_i, n_r;
  logic [GAP_W-1:0]  g_r;
  logic [31:0]       prev, mag_r;
  logic [63:0]       prod;
  logic signed [SUM_W-1:0] sum;
  logic [SQ_W-1:0]   sq;
  logic [S2_W-1:0]   gq, diff;
  logic [31:0]       ring_mag [SP];
  logic [SP-1:0]     ring_vld;

  logic [DIVN_W-1:0] div_num, div_q, div_q_next;
  logic [GAP_W-1:0]  div_rem, div_rem_next;
  logic [GAP_W:0]    div_sh;
  logic              div_ge;
  logic [DIVC_W-1:0] div_cnt;

  logic [LHS_W-1:0]  mul_a, mul_acc, mul_acc_next;
  logic [S_W-1:0]    mul_b;
  logic [MULC_W-1:0] mul_cnt;

  logic [31:0]       med_cand, med_val, med_c, tap;
  logic              med_cvld, tap_lt, tap_le, med_hit;
  logic [HELD_W-1:0] med_step, less_c, le_c, med_k;
  logic [SLOT_W-1:0] med_i, win_step;
  logic [GAP_W-1:0]  inwin;
  logic [35:0]       tap10, m7, m13;
  logic              in_win;

  logic [1:0]  res_strength;
  logic [31:0] res_median;
  logic [39:0] res_mean;
  logic [8:0]  res_conc;

  logic              key_match, ignored, quiet, act_record, act_refresh, act_classify;
  logic [S_W-1:0]    s_val;
  logic              sum_pos, t1_ok, conc_ok;
  logic [SLOT_W:0]   rd_slot_sum;
  logic [SLOT_W-1:0] start_slot, rd_slot;
  logic signed [32:0] gap_d;
  logic [31:0]       gap_mag;
  logic [HELD_W-1:0] out_count;

  assign busy = (state != pbfd_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_refresh_gap  <= 16'd5;
      cfg_min_lj       <= 5'd6;
      cfg_min_con      <= 5'd8;
      cfg_min_interval <= 16'd5;
      cfg_max_jitter   <= 8'd26;
      cfg_min_conc     <= 9'd154;
    end else if (cfg_we) begin
      case (pbfd_pkg::cfg_idx_t'(cfg_index))
        pbfd_pkg::CFG_REFRESH_GAP:     cfg_refresh_gap  <= cfg_data;
        pbfd_pkg::CFG_MIN_SAMPLES_LJ:  cfg_min_lj       <= cfg_data[4:0];
        pbfd_pkg::CFG_MIN_SAMPLES_CON: cfg_min_con      <= cfg_data[4:0];
        pbfd_pkg::CFG_MIN_INTERVAL:    cfg_min_interval <= cfg_data;
        pbfd_pkg::CFG_MAX_JITTER:      cfg_max_jitter   <= cfg_data[7:0];
        pbfd_pkg::CFG_MIN_CONC:        cfg_min_conc     <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    meta_rd <= meta_mem[meta_raddr];
  end

  always_ff @(posedge clk) begin
    if (arr_we) begin
      arr_mem[arr_waddr] <= req.time_now;
    end
    arr_rd <= arr_mem[arr_raddr];
  end

  always_comb begin
    key_match = pend_vld && (meta_rd.port == req.remote_port_num)
                && (meta_rd.addr_hi == req.addr_hi) && (meta_rd.addr_lo == req.addr_lo);
    ignored = (req.func == pbfd_pkg::FUNC_SIGHT)
              && ((req.remote_port_num == 16'd0) || ((req.addr_hi == 64'd0) && (req.addr_lo == 64'd0)));
    quiet = (req.time_now >= hit_meta.last_seen)
            && ((req.time_now - hit_meta.last_seen) >= {16'd0, cfg_refresh_gap});
    act_record = (req.func == pbfd_pkg::FUNC_OBSERVE)
                 || ((req.func == pbfd_pkg::FUNC_SIGHT) && !ignored && (!hit_r || quiet));
    act_refresh = (req.func == pbfd_pkg::FUNC_SIGHT) && !ignored && hit_r && !quiet;
    act_classify = (req.func == pbfd_pkg::FUNC_CLASSIFY) && hit_r
                   && (hit_meta.held >= HELD_W'(2));

    if (hit_r) begin
      new_idx = hit_idx;
    end else if (cnt < COUNT_W'(TE)) begin
      new_idx = cnt[ENTRY_W-1:0];
    end else begin
      new_idx = vic_idx;
    end
    if (hit_r) begin
      base_meta = hit_meta;
    end else begin
      base_meta = '{addr_hi: req.addr_hi, addr_lo: req.addr_lo, port: req.remote_port_num,
                    last_seen: 32'd0, write_slot: '0, held: '0};
    end
    rec_meta = base_meta;
    rec_meta.last_seen = req.time_now;
    rec_meta.write_slot = (base_meta.write_slot == SLOT_W'(SP - 1)) ? '0
                          : base_meta.write_slot + SLOT_W'(1);
    rec_meta.held = (base_meta.held < HELD_W'(SP)) ? base_meta.held + HELD_W'(1)
                    : base_meta.held;

    meta_raddr = scan_cnt[ENTRY_W-1:0];
    meta_we    = (state == pbfd_pkg::S_DECIDE) && (act_record || act_refresh);
    meta_waddr = act_record ? new_idx : hit_idx;
    meta_wdata = hit_meta;
    meta_wdata.last_seen = req.time_now;
    if (act_record) begin
      meta_wdata = rec_meta;
    end
    arr_we    = (state == pbfd_pkg::S_DECIDE) && act_record;
    arr_waddr = ARR_AW'(ARR_AW'(new_idx) * ARR_AW'(SP)) + ARR_AW'(base_meta.write_slot);
    out_count = act_record ? rec_meta.held : (hit_r ? hit_meta.held : '0);

    start_slot  = (n_r == HELD_W'(SP)) ? hit_meta.write_slot : '0;
    rd_slot_sum = {1'b0, start_slot} + (SLOT_W + 1)'(ld_i);
    rd_slot     = (rd_slot_sum >= (SLOT_W + 1)'(SP)) ? SLOT_W'(rd_slot_sum - (SLOT_W + 1)'(SP))
                  : rd_slot_sum[SLOT_W-1:0];
    arr_raddr   = ARR_AW'(ARR_AW'(hit_idx) * ARR_AW'(SP)) + ARR_AW'(rd_slot);

    gap_d   = $signed({1'b0, arr_rd}) - $signed({1'b0, prev});
    gap_mag = gap_d[32] ? 32'(-gap_d) : gap_d[31:0];

    s_val   = sum[S_W-1:0];
    sum_pos = !sum[SUM_W-1] && (sum != '0);
    t1_ok   = ({3'b0, n_r} >= {3'b0, cfg_min_lj})
              && (s_val >= S_W'(S_W'(cfg_min_interval) * S_W'(g_r)));
    conc_ok = ({3'b0, n_r} >= {3'b0, cfg_min_con});

    div_sh       = {div_rem, div_num[DIVN_W-1]};
    div_ge       = div_sh >= {1'b0, g_r};
    div_rem_next = div_ge ? GAP_W'(div_sh - {1'b0, g_r}) : div_sh[GAP_W-1:0];
    div_q_next   = {div_q[DIVN_W-2:0], div_ge};

    mul_acc_next = mul_b[0] ? mul_acc + mul_a : mul_acc;

    tap     = ring_mag[0];
    med_c   = (med_step == '0) ? tap : med_cand;
    tap_lt  = ring_vld[0] && (tap < med_c);
    tap_le  = ring_vld[0] && (tap <= med_c);
    med_k   = HELD_W'(g_r >> 1);
    med_hit = med_cvld && (less_c <= med_k) && (med_k < le_c);

    tap10  = {1'b0, tap, 3'b0} + {3'b0, tap, 1'b0};
    m7     = {1'b0, med_val, 3'b0} - {4'b0, med_val};
    m13    = {1'b0, med_val, 3'b0} + {2'b0, med_val, 2'b0} + {4'b0, med_val};
    in_win = ring_vld[0] && (tap10 >= m7) && (tap10 <= m13);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pbfd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pbfd_pkg::S_IDLE:      if (start) state_next = pbfd_pkg::S_SCAN;
      pbfd_pkg::S_SCAN:      if ((scan_cnt == cnt) && !pend_vld) state_next = pbfd_pkg::S_DECIDE;
      pbfd_pkg::S_DECIDE:    state_next = act_classify ? pbfd_pkg::S_CL_RD : pbfd_pkg::S_IDLE;
      pbfd_pkg::S_CL_RD:     state_next = pbfd_pkg::S_CL_DAT;
      pbfd_pkg::S_CL_DAT:    state_next = (ld_i == '0) ? pbfd_pkg::S_CL_RD : pbfd_pkg::S_CL_MUL;
      pbfd_pkg::S_CL_MUL:    state_next = pbfd_pkg::S_CL_ACC;
      pbfd_pkg::S_CL_ACC:    state_next = (ld_i + HELD_W'(1) == n_r) ? pbfd_pkg::S_POST
                                          : pbfd_pkg::S_CL_RD;
      pbfd_pkg::S_POST:      state_next = sum_pos ? pbfd_pkg::S_MEAN_DIV : pbfd_pkg::S_CONC;
      pbfd_pkg::S_MEAN_DIV:  if (div_cnt == DIVC_W'(1)) begin
        state_next = t1_ok ? pbfd_pkg::S_SQ_MUL : pbfd_pkg::S_CONC;
      end
      pbfd_pkg::S_SQ_MUL:    if (mul_cnt == MULC_W'(1)) state_next = pbfd_pkg::S_RHS_MUL;
      pbfd_pkg::S_RHS_MUL:   if (mul_cnt == MULC_W'(1)) state_next = pbfd_pkg::S_T1_CMP;
      pbfd_pkg::S_T1_CMP:    state_next = pbfd_pkg::S_CONC;
      pbfd_pkg::S_CONC:      state_next = conc_ok ? pbfd_pkg::S_MED : pbfd_pkg::S_FINISH;
      pbfd_pkg::S_MED:       if ((med_step == HELD_W'(SP)) && (med_i == SLOT_W'(SP - 1))) begin
        state_next = pbfd_pkg::S_MED_CHK;
      end
      pbfd_pkg::S_MED_CHK:   state_next = (med_val >= {16'd0, cfg_min_interval}) ? pbfd_pkg::S_WIN
                                          : pbfd_pkg::S_FINISH;
      pbfd_pkg::S_WIN:       if (win_step == SLOT_W'(SP - 1)) state_next = pbfd_pkg::S_CONC_INIT;
      pbfd_pkg::S_CONC_INIT: state_next = pbfd_pkg::S_CONC_DIV;
      pbfd_pkg::S_CONC_DIV:  if (div_cnt == DIVC_W'(1)) state_next = pbfd_pkg::S_CONC_END;
      pbfd_pkg::S_CONC_END:  state_next = pbfd_pkg::S_FINISH;
      pbfd_pkg::S_FINISH:    state_next = pbfd_pkg::S_IDLE;
      default:               state_next = pbfd_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      done     <= 1'b0;
      pend_vld <= 1'b0;
    end else begin
      done <= ((state == pbfd_pkg::S_DECIDE) && !act_classify)
              || (state == pbfd_pkg::S_FINISH);
      case (state)
        pbfd_pkg::S_IDLE: begin
          if (start) begin
            req      <= item;
            scan_cnt <= '0;
            pend_vld <= 1'b0;
            hit_r    <= 1'b0;
          end
        end
        pbfd_pkg::S_SCAN: begin
          pend_vld <= scan_cnt < cnt;
          pend_idx <= scan_cnt[ENTRY_W-1:0];
          if (scan_cnt < cnt) begin
            scan_cnt <= scan_cnt + COUNT_W'(1);
          end
          if (key_match && !hit_r) begin
            hit_r    <= 1'b1;
            hit_idx  <= pend_idx;
            hit_meta <= meta_rd;
          end
          if (pend_vld && ((pend_idx == '0) || (meta_rd.last_seen < vic_ls))) begin
            vic_idx <= pend_idx;
            vic_ls  <= meta_rd.last_seen;
          end
        end
        pbfd_pkg::S_DECIDE: begin
          if (act_record && !hit_r && (cnt < COUNT_W'(TE))) begin
            cnt <= cnt + COUNT_W'(1);
          end
          result       <= '{hit: hit_r && (req.func != pbfd_pkg::FUNC_NONE),
                            strength: 2'd0,
                            arrival_count: (req.func == pbfd_pkg::FUNC_NONE) ? 5'd0
                                           : 5'(out_count),
                            median_gap: 32'd0, mean_gap_q8: 40'd0, concentration_q8: 9'd0};
          n_r          <= hit_meta.held;
          g_r          <= GAP_W'(hit_meta.held - HELD_W'(1));
          ld_i         <= '0;
          sum          <= '0;
          sq           <= '0;
          ring_vld     <= '0;
          res_strength <= 2'd0;
          res_median   <= '0;
          res_mean     <= '0;
          res_conc     <= '0;
        end
        pbfd_pkg::S_CL_DAT: begin
          prev <= arr_rd;
          if (ld_i == '0) begin
            ld_i <= HELD_W'(1);
          end else begin
            mag_r <= gap_mag;
            sum   <= sum + SUM_W'(gap_d);
            for (int k = 0; k < SP - 1; k++) begin
              ring_mag[k] <= ring_mag[k + 1];
            end
            ring_mag[SP-1] <= gap_mag;
            ring_vld <= {1'b1, ring_vld[SP-1:1]};
          end
        end
        pbfd_pkg::S_CL_MUL: begin
          prod <= mag_r * mag_r;
        end
        pbfd_pkg::S_CL_ACC: begin
          sq   <= sq + SQ_W'(prod);
          ld_i <= ld_i + HELD_W'(1);
        end
        pbfd_pkg::S_POST: begin
          gq      <= S2_W'(S2_W'(g_r) * S2_W'(sq));
          div_num <= {s_val, 8'd0};
          div_rem <= '0;
          div_q   <= '0;
          div_cnt <= DIVC_W'(DIVN_W);
        end
        pbfd_pkg::S_MEAN_DIV, pbfd_pkg::S_CONC_DIV: begin
          div_num <= {div_num[DIVN_W-2:0], 1'b0};
          div_rem <= div_rem_next;
          div_q   <= div_q_next;
          div_cnt <= div_cnt - DIVC_W'(1);
          if ((div_cnt == DIVC_W'(1)) && (state == pbfd_pkg::S_MEAN_DIV)) begin
            res_mean <= div_q_next[39:0];
          end
          if ((div_cnt == DIVC_W'(1)) && (state == pbfd_pkg::S_CONC_DIV)) begin
            res_conc <= div_q_next[8:0];
          end
          mul_a   <= LHS_W'(s_val);
          mul_b   <= s_val;
          mul_acc <= '0;
          mul_cnt <= MULC_W'(S_W);
        end
        pbfd_pkg::S_SQ_MUL, pbfd_pkg::S_RHS_MUL: begin
          if ((mul_cnt == MULC_W'(1)) && (state == pbfd_pkg::S_SQ_MUL)) begin
            diff    <= gq - mul_acc_next[S2_W-1:0];
            mul_a   <= mul_acc_next;
            mul_b   <= S_W'(cfg_max_jitter * cfg_max_jitter);
            mul_acc <= '0;
            mul_cnt <= MULC_W'(16);
          end else begin
            mul_acc <= mul_acc_next;
            mul_a   <= {mul_a[LHS_W-2:0], 1'b0};
            mul_b   <= {1'b0, mul_b[S_W-1:1]};
            mul_cnt <= mul_cnt - MULC_W'(1);
          end
        end
        pbfd_pkg::S_T1_CMP: begin
          if ({diff, 16'd0} <= mul_acc) begin
            res_strength <= 2'd1;
          end
        end
        pbfd_pkg::S_CONC: begin
          med_step <= '0;
          med_i    <= '0;
          med_val  <= '0;
        end
        pbfd_pkg::S_MED: begin
          for (int k = 0; k < SP - 1; k++) begin
            ring_mag[k] <= ring_mag[k + 1];
          end
          ring_mag[SP-1] <= ring_mag[0];
          ring_vld <= {ring_vld[0], ring_vld[SP-1:1]};
          if (med_step == HELD_W'(SP)) begin
            if (med_hit) begin
              med_val <= med_cand;
            end
            med_step <= '0;
            med_i    <= med_i + SLOT_W'(1);
          end else begin
            if (med_step == '0) begin
              med_cand <= tap;
              med_cvld <= ring_vld[0];
              less_c   <= HELD_W'(tap_lt);
              le_c     <= HELD_W'(tap_le);
            end else begin
              less_c <= less_c + HELD_W'(tap_lt);
              le_c   <= le_c + HELD_W'(tap_le);
            end
            med_step <= med_step + HELD_W'(1);
          end
        end
        pbfd_pkg::S_MED_CHK: begin
          if (med_val >= {16'd0, cfg_min_interval}) begin
            res_median <= med_val;
          end
          win_step <= '0;
          inwin    <= '0;
        end
        pbfd_pkg::S_WIN: begin
          for (int k = 0; k < SP - 1; k++) begin
            ring_mag[k] <= ring_mag[k + 1];
          end
          ring_mag[SP-1] <= ring_mag[0];
          ring_vld <= {ring_vld[0], ring_vld[SP-1:1]};
          if (in_win) begin
            inwin <= inwin + GAP_W'(1);
          end
          win_step <= win_step + SLOT_W'(1);
        end
        pbfd_pkg::S_CONC_INIT: begin
          div_num <= {inwin, 8'd0, (DIVN_W - GAP_W - 8)'(0)};
          div_rem <= '0;
          div_q   <= '0;
          div_cnt <= DIVC_W'(GAP_W + 8);
        end
        pbfd_pkg::S_CONC_END: begin
          if ((res_strength == 2'd0)
              && ({1'b0, inwin, 8'd0} >= CW'(CW'(cfg_min_conc) * CW'(g_r)))) begin
            res_strength <= 2'd2;
          end
        end
        pbfd_pkg::S_FINISH: begin
          result <= '{hit: 1'b1, strength: res_strength, arrival_count: 5'(n_r),
                      median_gap: res_median, mean_gap_q8: res_mean,
                      concentration_q8: res_conc};
        end
        default: ;
      endcase
    end
  end

  `PBFD_ASSERT_NXT(a_done_single, done, !done, "Result strobe held for more than one cycle.")
  `PBFD_ASSERT_NXT(a_accept_busy, start && !busy, busy, "Accepted beat did not start work.")
  `PBFD_ASSERT_IMP(a_table_bound, 1'b1, cnt <= COUNT_W'(TE), "Table fill count overran.")
  `PBFD_ASSERT_IMP(a_strength_hit, done && (result.strength != 2'd0), result.hit,
                   "Classification reported for an absent flow.")
  `PBFD_ASSERT_IMP(a_write_decide, meta_we || arr_we, state == pbfd_pkg::S_DECIDE,
                   "Memory written outside the update cycle.")

endmodule
